// ===== hw/rtl/lad_pkg.sv =====
// Package for the linear array deque: item types, operation and status codes,
// and the controller command struct. No dependencies.
package lad_pkg;

    // Configuration register
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes carried in func
    localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [2:0] FUNC_PUSH_REAR  = 3'd1;
    localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [2:0] FUNC_POP_REAR   = 3'd3;
    localparam logic [2:0] FUNC_CLEAR      = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_FULL          = 3'd1;
    localparam logic [2:0] ST_FRONT_BLOCKED = 3'd2;
    localparam logic [2:0] ST_REAR_BLOCKED  = 3'd3;
    localparam logic [2:0] ST_EMPTY         = 3'd4;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pop_value;
        logic [2:0]         status;
        logic               now_empty;
        logic               now_full;
    } out_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the accepted item
        logic execute;   // apply the operation, read/write the slot memory
        logic load_out;  // load the output register
    } lad_cmd_t;

endpackage

// ===== hw/rtl/lad_ctrl.sv =====
// Controller for the linear array deque: sequences capture, execute and
// output load for one item at a time. Depends on lad_pkg.
module lad_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output lad_pkg::lad_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;
    logic   m_valid_reg;

    // Commands decoded from the current state and the handshake signals
    always_comb begin
        cmd.capture  = s_valid && s_ready_reg;
        cmd.execute  = (state_reg == ST_EXEC);
        cmd.load_out = (state_reg == ST_RESP) && (!m_valid_reg || m_ready);
    end

    // State and registered handshake outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            // Result valid: set on output load, cleared when taken
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        state_reg   <= ST_EXEC;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_EXEC: begin
                    state_reg <= ST_RESP;
                end
                ST_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    s_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

// ===== hw/rtl/lad_datapath.sv =====
// Datapath for the linear array deque: capacity register, end pointers,
// slot memory and output register. Depends on lad_pkg.
module lad_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lad_pkg::lad_cmd_t                   cmd,
    input  lad_pkg::in_item_t                   in_item,
    input  logic                                cfg_wr_en,
    input  logic [lad_pkg::CAP_W-1:0]           cfg_wr_data,
    output lad_pkg::out_item_t                  out_item
);

    localparam int IW = $clog2(DEPTH);
    localparam int LW = (IW + 1 > lad_pkg::CAP_W) ? IW + 1 : lad_pkg::CAP_W;

    logic [lad_pkg::CAP_W-1:0] cap_reg;
    logic [IW-1:0]             front_reg, front_next;
    logic [IW-1:0]             rear_reg, rear_next;
    logic                      empty_reg, empty_next;
    lad_pkg::in_item_t         op_reg;
    logic [2:0]                status_reg, status_next;
    logic                      popped_reg, popped_next;
    logic signed [31:0]        rdata_reg;
    lad_pkg::out_item_t        out_reg;

    logic signed [31:0] mem [DEPTH];

    logic [LW-1:0] cap_ext, eff_cap, last_idx;
    logic          rear_at_last, is_full;
    logic          wr_en;
    logic [IW-1:0] wr_addr, rd_addr;

    // Effective capacity: zero acts as one, above DEPTH acts as DEPTH
    always_comb begin
        cap_ext = LW'(cap_reg);
        if (cap_reg == '0) begin
            eff_cap = LW'(1);
        end else if (cap_ext > LW'(DEPTH)) begin
            eff_cap = LW'(DEPTH);
        end else begin
            eff_cap = cap_ext;
        end
        last_idx     = eff_cap - LW'(1);
        rear_at_last = LW'(rear_reg) >= last_idx;
        is_full      = !empty_reg && (front_reg == '0) && rear_at_last;
    end

    // Operation decode and next pointer state
    always_comb begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        empty_next  = empty_reg;
        status_next = lad_pkg::ST_OK;
        popped_next = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = front_reg;
        rd_addr     = front_reg;
        case (op_reg.func)
            lad_pkg::FUNC_PUSH_FRONT, lad_pkg::FUNC_PUSH_REAR: begin
                if (is_full) begin
                    status_next = lad_pkg::ST_FULL;
                end else if (empty_reg) begin
                    empty_next = 1'b0;
                    front_next = '0;
                    rear_next  = '0;
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                end else if (op_reg.func == lad_pkg::FUNC_PUSH_FRONT) begin
                    if (front_reg == '0) begin
                        status_next = lad_pkg::ST_FRONT_BLOCKED;
                    end else begin
                        front_next = front_reg - IW'(1);
                        wr_en      = 1'b1;
                        wr_addr    = front_reg - IW'(1);
                    end
                end else begin
                    if (rear_at_last) begin
                        status_next = lad_pkg::ST_REAR_BLOCKED;
                    end else begin
                        rear_next = rear_reg + IW'(1);
                        wr_en     = 1'b1;
                        wr_addr   = rear_reg + IW'(1);
                    end
                end
            end
            lad_pkg::FUNC_POP_FRONT, lad_pkg::FUNC_POP_REAR: begin
                if (empty_reg) begin
                    status_next = lad_pkg::ST_EMPTY;
                end else if (front_reg == rear_reg) begin
                    popped_next = 1'b1;
                    rd_addr     = front_reg;
                    empty_next  = 1'b1;
                    front_next  = '0;
                    rear_next   = '0;
                end else if (op_reg.func == lad_pkg::FUNC_POP_FRONT) begin
                    popped_next = 1'b1;
                    rd_addr     = front_reg;
                    front_next  = front_reg + IW'(1);
                end else begin
                    popped_next = 1'b1;
                    rd_addr     = rear_reg;
                    rear_next   = rear_reg - IW'(1);
                end
            end
            lad_pkg::FUNC_CLEAR: begin
                empty_next = 1'b1;
                front_next = '0;
                rear_next  = '0;
            end
            default: begin
            end
        endcase
    end

    // Control state: capacity and pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= lad_pkg::CAP_RESET;
            front_reg <= '0;
            rear_reg  <= '0;
            empty_reg <= 1'b1;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.execute) begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
                empty_reg <= empty_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg <= in_item;
        end
        if (cmd.execute) begin
            status_reg <= status_next;
            popped_reg <= popped_next;
        end
        if (cmd.load_out) begin
            out_reg.pop_value <= popped_reg ? rdata_reg : 32'sd0;
            out_reg.status    <= status_reg;
            out_reg.now_empty <= empty_reg;
            out_reg.now_full  <= is_full;
        end
    end

    // Slot memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (cmd.execute && wr_en) begin
            mem[wr_addr] <= op_reg.push_value;
        end
        if (cmd.execute) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign out_item = out_reg;

endmodule

// ===== hw/rtl/linear_array_deque_top.sv =====
// Linear array deque, top level: wires the controller to the datapath.
// Each item passes in order through capture, execute with the slot memory
// access and output load; a new item is accepted only after the last one's
// result is loaded, so a stalled result holds off the next item.
// Reset: synchronous active-low aresetn empties the deque and sets capacity
// to 16; slot contents are not cleared.
module linear_array_deque_top #(
    parameter int DEPTH = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  lad_pkg::in_item_t         s_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output lad_pkg::out_item_t        m_item,
    input  logic                      cfg_wr_en,
    input  logic [lad_pkg::CAP_W-1:0] cfg_wr_data
);

    lad_pkg::lad_cmd_t cmd;

    lad_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    lad_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_item     (s_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_item    (m_item)
    );

endmodule
